// ===== rtl/core/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants for the stepper pulse generator: command codes,
// register indexes, fixed field widths and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package spg_pkg;

  // Default build widths
  localparam int INTERVAL_WIDTH_DEF = 16;
  localparam int POSITION_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int VEL_W   = 21;
  localparam int LOAD_W  = 24;
  localparam int TGT_W   = 32;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int OUTPOS_W = 32;

  // Half-period arithmetic: pitch * 125000 / (ppr * |v|)
  localparam int                TICKS_W   = 17;
  localparam logic [TICKS_W-1:0] TICKS_NUM = 17'd125000;
  localparam int                NUM_W     = CFG_W + TICKS_W;   // 33
  localparam int                DEN_W     = CFG_W + VEL_W;     // 37
  localparam logic [VEL_W-1:0]  MIN_SPEED = 21'd1;

  // Request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET_VEL = 2'd1,
    CMD_HOME    = 2'd2,
    CMD_ARM     = 2'd3
  } cmd_e_t;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PITCH = 2'd0;
  localparam logic [IDX_W-1:0] REG_PPR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_UIR   = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted request
    logic decode;     // products and tick look-ahead
    logic div_start;  // launch the serial divide
    logic commit;     // update state and present the result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_div;
    logic div_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/spg_div.sv =====
// ----------------------------------------------------------------------------
// spg_div
// Restoring unsigned divider, one quotient bit per cycle. Division by zero
// yields an all-ones quotient, which the caller saturates.
// ----------------------------------------------------------------------------
module spg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [spg_pkg::NUM_W-1:0] num,
  input  logic [spg_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [spg_pkg::NUM_W-1:0] quot
);
  import spg_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // trial subtract
  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = ~diff[DEN_W+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // shift/subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign quot = quo;

endmodule

// ===== rtl/core/spg_datapath.sv =====
// ----------------------------------------------------------------------------
// spg_datapath
// Configuration registers, request capture, interval arithmetic and the
// motor state (pulse, direction, tick counter, step count, limit, homing).
// ----------------------------------------------------------------------------
module spg_datapath #(
  parameter int INTERVAL_WIDTH = spg_pkg::INTERVAL_WIDTH_DEF,
  parameter int POSITION_WIDTH = spg_pkg::POSITION_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [spg_pkg::IDX_W-1:0]          cfg_index,
  input  logic [spg_pkg::CFG_W-1:0]          cfg_data,
  input  logic [spg_pkg::CMD_W-1:0]          command,
  input  logic signed [spg_pkg::VEL_W-1:0]   velocity,
  input  logic signed [spg_pkg::LOAD_W-1:0]  homing_threshold,
  input  logic signed [spg_pkg::LOAD_W-1:0]  measured_load,
  input  logic signed [spg_pkg::TGT_W-1:0]   target_position,
  input  spg_pkg::ctl_cmd_t                  ctl,
  output spg_pkg::dp_status_t                status,
  output logic                               pulse_level,
  output logic                               direction,
  output logic                               running,
  output logic signed [spg_pkg::OUTPOS_W-1:0] step_position,
  output logic                               zero_reached,
  output logic                               limit_stop
);
  import spg_pkg::*;

  localparam int IW = INTERVAL_WIDTH;
  localparam int PW = POSITION_WIDTH;
  localparam logic [IW-1:0]        IMAX    = {IW{1'b1}};
  localparam logic signed [PW-1:0] POS_ONE = PW'(1);

  // configuration
  logic [CFG_W-1:0] pitch;
  logic [CFG_W-1:0] ppr;
  logic             uir;

  // captured request
  cmd_e_t                    cmd_q;
  logic [VEL_W-1:0]          mag_q;
  logic                      neg_q;
  logic signed [LOAD_W-1:0]  thr_q;
  logic signed [LOAD_W-1:0]  load_q;
  logic signed [TGT_W-1:0]   tgt_q;
  logic [VEL_W-1:0]          mag_in;

  // decode stage
  logic [NUM_W-1:0]          num_q;
  logic [DEN_W-1:0]          den_q;
  logic [IW-1:0]             tick_inc_q;
  logic                      wrap_q;
  logic signed [PW-1:0]      step_new_q;
  logic [IW-1:0]             tick_inc;
  logic signed [PW-1:0]      step_mv;

  // motor state
  logic                      pulse_reg, pulse_next;
  logic                      dir_reg, dir_next;
  logic                      run_reg, run_next;
  logic [IW-1:0]             half_period, half_period_next;
  logic [IW-1:0]             tick_count, tick_count_next;
  logic signed [PW-1:0]      step_count, step_count_next;
  logic                      limit_armed, limit_armed_next;
  logic signed [TGT_W-1:0]   limit_target, limit_target_next;
  logic                      homing_active, homing_active_next;
  logic signed [LOAD_W-1:0]  homing_level, homing_level_next;
  logic                      zflag, lflag;

  // divider
  logic [NUM_W-1:0]          quot;
  logic                      div_busy;
  logic [IW-1:0]             ivl_sat;

  spg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (num_q),
    .den   (den_q),
    .busy  (div_busy),
    .quot  (quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= 16'd5000;
      ppr   <= 16'd200;
      uir   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PITCH: pitch <= cfg_data;
        REG_PPR:   ppr   <= cfg_data;
        REG_UIR:   uir   <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // request capture; magnitude of -2^20 fits as unsigned
  assign mag_in = velocity[VEL_W-1] ? VEL_W'(-velocity) : VEL_W'(velocity);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd_e_t'(command);
      mag_q  <= mag_in;
      neg_q  <= velocity[VEL_W-1];
      thr_q  <= homing_threshold;
      load_q <= measured_load;
      tgt_q  <= target_position;
    end
  end

  // tick look-ahead: counter increment and step move on a falling edge
  always_comb begin
    tick_inc = tick_count + IW'(1);
    step_mv  = (dir_reg == uir) ? step_count + POS_ONE : step_count - POS_ONE;
  end

  always_ff @(posedge clk) begin
    if (ctl.decode) begin
      num_q      <= NUM_W'(pitch) * NUM_W'(TICKS_NUM);
      den_q      <= DEN_W'(ppr) * DEN_W'(mag_q);
      tick_inc_q <= tick_inc;
      wrap_q     <= (tick_inc >= half_period);
      step_new_q <= pulse_reg ? step_mv : step_count;
    end
  end

  assign status.needs_div = ((cmd_q == CMD_SET_VEL) || (cmd_q == CMD_HOME)) &&
                            (mag_q > MIN_SPEED);
  assign status.div_busy  = div_busy;

  // saturate quotient to the interval range
  assign ivl_sat = (|(quot >> IW)) ? IMAX : quot[IW-1:0];

  // next state of the motor
  always_comb begin
    pulse_next         = pulse_reg;
    dir_next           = dir_reg;
    run_next           = run_reg;
    half_period_next   = half_period;
    tick_count_next    = tick_count;
    step_count_next    = step_count;
    limit_armed_next   = limit_armed;
    limit_target_next  = limit_target;
    homing_active_next = homing_active;
    homing_level_next  = homing_level;
    zflag              = 1'b0;
    lflag              = 1'b0;
    unique case (cmd_q) inside
      CMD_SET_VEL, CMD_HOME: begin
        if (cmd_q == CMD_HOME) begin
          homing_active_next = 1'b1;
          homing_level_next  = thr_q;
        end
        if (mag_q > MIN_SPEED) begin
          // homing always heads down
          dir_next = (cmd_q == CMD_HOME) ? ~uir : neg_q;
          if (ivl_sat != '0) begin
            half_period_next = ivl_sat;
            tick_count_next  = ivl_sat - IW'(1);
            run_next         = 1'b1;
          end else begin
            run_next = 1'b0;
          end
        end else begin
          run_next   = 1'b0;
          pulse_next = 1'b0;
        end
      end
      CMD_ARM: begin
        limit_armed_next  = 1'b1;
        limit_target_next = tgt_q;
      end
      CMD_TICK: begin
        if (run_reg) begin
          tick_count_next = wrap_q ? '0 : tick_inc_q;
          if (wrap_q) begin
            pulse_next      = ~pulse_reg;
            step_count_next = step_new_q;
            // limit: past target in the travel direction
            if (limit_armed && ((step_new_q > limit_target) != dir_reg)) begin
              run_next         = 1'b0;
              pulse_next       = 1'b0;
              limit_armed_next = 1'b0;
              lflag            = 1'b1;
            end
            // homing: load reached, zero the position
            if (homing_active && (load_q >= homing_level)) begin
              run_next           = 1'b0;
              pulse_next         = 1'b0;
              step_count_next    = '0;
              homing_active_next = 1'b0;
              zflag              = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // state and flags update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_reg     <= 1'b0;
      dir_reg       <= 1'b0;
      run_reg       <= 1'b0;
      half_period   <= '0;
      tick_count    <= '0;
      step_count    <= '0;
      limit_armed   <= 1'b0;
      limit_target  <= '0;
      homing_active <= 1'b0;
      homing_level  <= '0;
      zero_reached  <= 1'b0;
      limit_stop    <= 1'b0;
    end else if (ctl.commit) begin
      pulse_reg     <= pulse_next;
      dir_reg       <= dir_next;
      run_reg       <= run_next;
      half_period   <= half_period_next;
      tick_count    <= tick_count_next;
      step_count    <= step_count_next;
      limit_armed   <= limit_armed_next;
      limit_target  <= limit_target_next;
      homing_active <= homing_active_next;
      homing_level  <= homing_level_next;
      zero_reached  <= zflag;
      limit_stop    <= lflag;
    end
  end

  // state holds until the result is taken, so it doubles as the result
  assign pulse_level = pulse_reg;
  assign direction   = dir_reg;
  assign running     = run_reg;

  generate
    if (PW >= OUTPOS_W) begin : g_pos_trunc
      assign step_position = step_count[OUTPOS_W-1:0];
    end else begin : g_pos_ext
      assign step_position = {{(OUTPOS_W-PW){1'b0}}, step_count};
    end
  endgenerate

endmodule

// ===== rtl/core/spg_ctrl.sv =====
// ----------------------------------------------------------------------------
// spg_ctrl
// Sequencer: capture, decode, optional serial divide, commit. Owns the
// input ready and the result valid flag.
// ----------------------------------------------------------------------------
module spg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  spg_pkg::dp_status_t status,
  output spg_pkg::ctl_cmd_t   ctl
);
  import spg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DECODE  = 5'b00010,
    S_DIVLOAD = 5'b00100,
    S_DIV     = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = ~out_valid | out_ready;
  assign in_ready  = (state == S_IDLE);

  // command decode
  always_comb begin
    ctl.load      = in_valid & in_ready;
    ctl.decode    = (state == S_DECODE);
    ctl.div_start = (state == S_DIVLOAD);
    ctl.commit    = (state == S_EMIT) & slot_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_DECODE;
      S_DECODE:  state_next = status.needs_div ? S_DIVLOAD : S_EMIT;
      S_DIVLOAD: state_next = S_DIV;
      S_DIV:     if (!status.div_busy) state_next = S_EMIT;
      S_EMIT:    if (slot_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/stepper_pulse_generator_with_homing.sv =====
// ----------------------------------------------------------------------------
// stepper_pulse_generator_with_homing
// Step/direction generator for a lead-screw stepper with a position limit
// and load-triggered homing; one result per request.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in       | in_valid  / in_ready   | command, velocity, homing_threshold,
//           |                        | measured_load, target_position
//  out      | out_valid / out_ready  | pulse_level, direction, running,
//           |                        | step_position, zero_reached, limit_stop
//
//  Tick, arm and slow-speed requests go from decode straight to commit; the
//  next request is accepted once the sequencer is back in idle.
//  Velocity and homing requests with |v| > 1 first pass through the serial
//  divider, which produces one quotient bit per cycle.
//  A new request is accepted while the previous result waits on out_ready;
//  it commits only once that result is taken. cfg_ready is always high.
//  Reset is synchronous; registers with a reset return to their reset values.
// ----------------------------------------------------------------------------
module stepper_pulse_generator_with_homing #(
  parameter int INTERVAL_WIDTH = spg_pkg::INTERVAL_WIDTH_DEF,
  parameter int POSITION_WIDTH = spg_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spg_pkg::IDX_W-1:0]           cfg_index,
  input  logic [spg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spg_pkg::CMD_W-1:0]           command,
  input  logic signed [spg_pkg::VEL_W-1:0]    velocity,
  input  logic signed [spg_pkg::LOAD_W-1:0]   homing_threshold,
  input  logic signed [spg_pkg::LOAD_W-1:0]   measured_load,
  input  logic signed [spg_pkg::TGT_W-1:0]    target_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                pulse_level,
  output logic                                direction,
  output logic                                running,
  output logic signed [spg_pkg::OUTPOS_W-1:0] step_position,
  output logic                                zero_reached,
  output logic                                limit_stop
);
  import spg_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  spg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctl       (ctl)
  );

  spg_datapath #(
    .INTERVAL_WIDTH (INTERVAL_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .command          (command),
    .velocity         (velocity),
    .homing_threshold (homing_threshold),
    .measured_load    (measured_load),
    .target_position  (target_position),
    .ctl              (ctl),
    .status           (status),
    .pulse_level      (pulse_level),
    .direction        (direction),
    .running          (running),
    .step_position    (step_position),
    .zero_reached     (zero_reached),
    .limit_stop       (limit_stop)
  );

  // one request in flight: no second acceptance straight after the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  // a result only appears after a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.commit))
    else $error("result valid without a commit");

  // homing completion stops the motor at position zero
  a_home_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_reached) |-> (!running && !pulse_level && step_position == '0))
    else $error("homing finished but motor not stopped at zero");

  // a limit stop leaves the motor idle with the pin low
  a_limit_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && limit_stop) |-> (!running && !pulse_level))
    else $error("limit stop reported while still running");

endmodule

// ===== verif/tb_stepper_pulse_generator_with_homing.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_pulse_generator_with_homing
// Self-checking bench for the stepper step/direction generator. A short
// table of directed requests covers standstill, the speed extremes, limit
// and homing stops and the degenerate intervals. Random motion episodes then
// follow under several register settings, mostly with random idling on both
// channels. Results are compared with an in-bench model or a typed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stepper_pulse_generator_with_homing;
  import spg_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 265;
  localparam int SETTLE_CYCLES = 45;
  localparam int IVL_W        = INTERVAL_WIDTH_DEF;
  localparam int POS_W        = POSITION_WIDTH_DEF;
  localparam longint unsigned IVL_MAX = (64'd1 << IVL_W) - 1;
  localparam int LOAD_MIN     = -8388608;
  localparam int LOAD_MAX     = 8388607;

  typedef struct packed {
    logic              pulse;
    logic              dir;
    logic              run;
    logic [POS_W-1:0]  pos;
    logic              zero;
    logic              lim;
  } motor_out_t;

  typedef struct packed {
    cmd_e_t             cmd;
    logic [VEL_W-1:0]   vel;
    logic [LOAD_W-1:0]  thr;
    logic [LOAD_W-1:0]  load;
    logic [TGT_W-1:0]   tgt;
  } motor_req_t;

  typedef struct packed {
    logic              is_cfg;
    logic [IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]  reg_val;
    motor_req_t        req;
    logic              typed;
    motor_out_t        want;
  } stim_row_t;

  // Block ports
  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           command = '0;
  logic signed [VEL_W-1:0]    velocity = '0;
  logic signed [LOAD_W-1:0]   homing_threshold = '0;
  logic signed [LOAD_W-1:0]   measured_load = '0;
  logic signed [TGT_W-1:0]    target_position = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       pulse_level;
  logic                       direction;
  logic                       running;
  logic signed [OUTPOS_W-1:0] step_position;
  logic                       zero_reached;
  logic                       limit_stop;

  // Model registers and state, at their reset values
  logic [CFG_W-1:0]          pitch_q = 16'd5000;
  logic [CFG_W-1:0]          ppr_q = 16'd200;
  logic                      up_rev_q = 1'b0;
  logic                      pulse_q = 1'b0;
  logic                      dir_q = 1'b0;
  logic                      run_q = 1'b0;
  logic [IVL_W-1:0]          half_q = '0;
  logic [IVL_W-1:0]          tick_q = '0;
  logic [POS_W-1:0]          pos_q = '0;
  logic                      arm_q = 1'b0;
  logic signed [TGT_W-1:0]   lim_tgt_q = '0;
  logic                      home_q = 1'b0;
  logic signed [LOAD_W-1:0]  home_lvl_q = '0;

  motor_out_t  due_outputs[$];
  stim_row_t   stim_table[$];
  motor_out_t  head_out;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          sent_cnt = 0;
  int          live_cnt = 0;
  int          toggle_cnt = 0;
  int          limit_cnt = 0;
  int          zero_cnt = 0;
  int          setting_cnt = 0;
  int unsigned in_idle_pct = 37;
  int unsigned out_idle_pct = 37;

  stepper_pulse_generator_with_homing u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .velocity         (velocity),
    .homing_threshold (homing_threshold),
    .measured_load    (measured_load),
    .target_position  (target_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pulse_level      (pulse_level),
    .direction        (direction),
    .running          (running),
    .step_position    (step_position),
    .zero_reached     (zero_reached),
    .limit_stop       (limit_stop)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Motor model
  // --------------------------------------------------------------------------

  // New speed: half-period from pitch*125000/(ppr*|v|), or a stop when slow
  function automatic void apply_velocity(longint v);
    longint unsigned mag, den, ivl;
    if (v > 1 || v < -1) begin
      mag = (v > 0) ? v : -v;
      den = mag * 64'(ppr_q);
      ivl = (den == 0) ? IVL_MAX : (64'(pitch_q) * 64'(TICKS_NUM)) / den;
      if (ivl > IVL_MAX) ivl = IVL_MAX;
      if (ivl != 0) begin
        half_q = ivl[IVL_W-1:0];
        tick_q = half_q - IVL_W'(1);
        run_q  = 1'b1;
      end else begin
        run_q = 1'b0;
      end
      dir_q = (v < 0);
    end else begin
      run_q   = 1'b0;
      pulse_q = 1'b0;
    end
  endfunction

  function automatic motor_out_t predict_motion(motor_req_t r);
    motor_out_t res;
    longint     vel, mag;
    logic       up;
    res = '0;
    vel = longint'($signed(r.vel));
    case (r.cmd)
      CMD_SET_VEL: apply_velocity(vel);
      CMD_HOME: begin
        mag        = (vel < 0) ? -vel : vel;
        home_q     = 1'b1;
        home_lvl_q = r.thr;
        apply_velocity(up_rev_q ? mag : -mag);
      end
      CMD_ARM: begin
        arm_q     = 1'b1;
        lim_tgt_q = r.tgt;
      end
      default: begin
        if (run_q) begin
          tick_q = tick_q + IVL_W'(1);
          if (tick_q >= half_q) begin
            tick_q  = '0;
            pulse_q = ~pulse_q;
            toggle_cnt++;
            // falling edge moves the count
            if (!pulse_q) begin
              up    = (dir_q == up_rev_q);
              pos_q = up ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
            end
            // limit stop: side of the target disagrees with the direction pin
            if (arm_q && ((($signed(pos_q) > lim_tgt_q) ? 1'b1 : 1'b0) ^ dir_q)) begin
              run_q   = 1'b0;
              pulse_q = 1'b0;
              arm_q   = 1'b0;
              res.lim = 1'b1;
              limit_cnt++;
            end
            if (home_q && ($signed(r.load) >= home_lvl_q)) begin
              run_q    = 1'b0;
              pulse_q  = 1'b0;
              pos_q    = '0;
              home_q   = 1'b0;
              res.zero = 1'b1;
              zero_cnt++;
            end
          end
        end
      end
    endcase
    res.pulse = pulse_q;
    res.dir   = dir_q;
    res.run   = run_q;
    res.pos   = pos_q;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request and register drivers
  // --------------------------------------------------------------------------

  task automatic send_req(input motor_req_t r, input logic typed, input motor_out_t want);
    motor_out_t got;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    command          <= r.cmd;
    velocity         <= r.vel;
    homing_threshold <= r.thr;
    measured_load    <= r.load;
    target_position  <= r.tgt;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    // ticks on a stopped motor do nothing and are not counted
    if (r.cmd != CMD_TICK || run_q) live_cnt++;
    got = predict_motion(r);
    due_outputs.push_back(typed ? want : got);
  endtask

  // Hold off requests until every result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PITCH: pitch_q = val;
      REG_PPR:   ppr_q = val;
      REG_UIR:   up_rev_q = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------

  function automatic void add_req(cmd_e_t c, int v, int th, int ld, int tg);
    stim_row_t row;
    row          = '0;
    row.req.cmd  = c;
    row.req.vel  = VEL_W'(v);
    row.req.thr  = LOAD_W'(th);
    row.req.load = LOAD_W'(ld);
    row.req.tgt  = tg;
    stim_table.push_back(row);
  endfunction

  // Row whose result is plain to see; position is zero in all of them
  function automatic void add_typed(cmd_e_t c, int v, int ld,
                                    logic p, logic d, logic rn, logic z, logic l);
    stim_row_t row;
    row          = '0;
    row.req.cmd  = c;
    row.req.vel  = VEL_W'(v);
    row.req.load = LOAD_W'(ld);
    row.typed    = 1'b1;
    row.want     = {p, d, rn, {POS_W{1'b0}}, z, l};
    stim_table.push_back(row);
  endfunction

  function automatic void add_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_table.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Random field pickers
  // --------------------------------------------------------------------------

  function automatic motor_req_t random_req();
    motor_req_t r;
    r.cmd  = cmd_e_t'($urandom_range(0, 3));
    r.vel  = VEL_W'($urandom);
    r.thr  = LOAD_W'($urandom);
    r.load = LOAD_W'($urandom);
    r.tgt  = $urandom;
    return r;
  endfunction

  // Mostly speeds that give a half-period of a few ticks
  function automatic logic [VEL_W-1:0] pick_speed();
    longint unsigned         mag;
    logic signed [VEL_W-1:0] s;
    int unsigned             roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return VEL_W'($urandom);
    if (roll == 1) return VEL_W'($urandom_range(0, 4) - 2);
    if (ppr_q == 0) mag = 2;
    else mag = (64'(pitch_q) * 64'(TICKS_NUM)) /
               (64'(ppr_q) * 64'($urandom_range(1, 6)));
    if (mag < 2) mag = 2;
    if (mag > 1048575) mag = 1048575;
    s = mag[VEL_W-1:0];
    return $urandom_range(0, 1) ? -s : s;
  endfunction

  function automatic logic [LOAD_W-1:0] pick_threshold();
    if ($urandom_range(0, 4) == 0) return LOAD_W'($urandom);
    return LOAD_W'($urandom_range(0, 4000) - 2000);
  endfunction

  // Loads mostly under the homing level, now and then at or above it
  function automatic logic [LOAD_W-1:0] pick_load();
    int l;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!home_q || roll < 8) return LOAD_W'($urandom);
    if (roll < 20) l = int'(home_lvl_q) + int'($urandom_range(0, 50));
    else l = int'(home_lvl_q) - int'($urandom_range(1, 3000));
    if (l > LOAD_MAX) l = LOAD_MAX;
    if (l < LOAD_MIN) l = LOAD_MIN;
    return LOAD_W'(l);
  endfunction

  function automatic logic [TGT_W-1:0] pick_target();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return pos_q + $urandom_range(0, 48) - 24;
  endfunction

  // Motion episodes: start or home, maybe a nearby limit, then a run of ticks;
  // about one episode in ten is a stray request with random content
  task automatic run_phase(input int n);
    int         stop_at;
    motor_req_t r;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(random_req(), 1'b0, '0);
      end else begin
        r     = random_req();
        r.vel = pick_speed();
        if ($urandom_range(0, 3) == 0) begin
          r.cmd = CMD_HOME;
          r.thr = pick_threshold();
        end else begin
          r.cmd = CMD_SET_VEL;
        end
        send_req(r, 1'b0, '0);
        if ($urandom_range(0, 1) == 1) begin
          r     = random_req();
          r.cmd = CMD_ARM;
          r.tgt = pick_target();
          send_req(r, 1'b0, '0);
        end
        repeat ($urandom_range(4, 40)) begin
          r      = random_req();
          r.cmd  = CMD_TICK;
          r.load = pick_load();
          send_req(r, 1'b0, '0);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking and back-pressure
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_outputs.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt++;
      end else begin
        head_out = due_outputs.pop_front();
        check_field("pulse_level", 64'(head_out.pulse), 64'(pulse_level));
        check_field("direction", 64'(head_out.dir), 64'(direction));
        check_field("running", 64'(head_out.run), 64'(running));
        check_field("step_position", 64'($signed(head_out.pos)), 64'(step_position));
        check_field("zero_reached", 64'(head_out.zero), 64'(zero_reached));
        check_field("limit_stop", 64'(head_out.lim), 64'(limit_stop));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("stepper_pulse_generator_with_homing test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] pv, rv, uv;

    // standstill and the top speed from reset
    add_typed(CMD_TICK, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_SET_VEL, 1, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_SET_VEL, -1, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_typed(CMD_SET_VEL, 1048575, 0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    repeat (3) add_req(CMD_TICK, 0, 0, 0, 0);
    // limit just behind the position stops on the next toggle
    add_req(CMD_ARM, 0, 0, 0, 0);
    repeat (2) add_req(CMD_TICK, 0, 0, 0, 0);
    add_req(CMD_SET_VEL, -1048576, 0, 0, 0);
    // homing at the lowest level ends on the first toggle
    add_req(CMD_HOME, 1048575, LOAD_MIN, 0, 0);
    add_typed(CMD_TICK, 0, LOAD_MIN, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    add_req(CMD_ARM, 0, 0, 0, 32'h7FFF_FFFF);
    add_req(CMD_ARM, 0, 0, 0, 32'h8000_0000);
    // homing requested at standstill stays pending while the motor is stopped
    add_req(CMD_HOME, 0, LOAD_MAX, 0, 0);
    add_req(CMD_TICK, 0, 0, LOAD_MAX, 0);
    // limit and homing fire on the same toggle
    add_req(CMD_SET_VEL, 1000000, 0, 0, 0);
    add_typed(CMD_TICK, 0, LOAD_MAX, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    // zero pulses per revolution saturates the interval
    add_cfg(REG_PPR, 16'd0);
    add_req(CMD_SET_VEL, 500, 0, 0, 0);
    add_req(CMD_TICK, 0, 0, 0, 0);
    // interval of zero stops the motor but keeps the pin
    add_cfg(REG_PITCH, 16'd1);
    add_cfg(REG_PPR, 16'hFFFF);
    add_req(CMD_SET_VEL, -3, 0, 0, 0);
    // reversed counting and homing at the most negative speed
    add_cfg(REG_PITCH, 16'd5000);
    add_cfg(REG_PPR, 16'd200);
    add_cfg(REG_UIR, 16'd1);
    add_req(CMD_HOME, -1048576, 0, 0, 0);
    add_req(CMD_TICK, 0, 0, -1, 0);
    add_req(CMD_TICK, 0, 0, 0, 0);
    add_req(CMD_TICK, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        drain_results();
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
      end else begin
        send_req(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin pv = 16'hFFFF; rv = 16'hFFFF; uv = 16'd0; end
        1: begin pv = 16'd1; rv = 16'd1; uv = 16'd1; end
        2: begin pv = 16'd5000; rv = 16'd200; uv = 16'd1; end
        3: begin pv = CFG_W'($urandom); rv = CFG_W'($urandom); uv = CFG_W'($urandom); end
        default: begin
          pv = CFG_W'($urandom_range(1, 300));
          rv = CFG_W'($urandom_range(1, 300));
          uv = CFG_W'($urandom_range(0, 1));
        end
      endcase
      // the third phase runs with no idling on either side
      in_idle_pct  = (ph == 2) ? 0 : 37;
      out_idle_pct = (ph == 2) ? 0 : 37;
      drain_results();
      write_reg(REG_PITCH, pv);
      write_reg(REG_PPR, rv);
      write_reg(REG_UIR, uv);
      setting_cnt++;
      run_phase(PHASE_ITEMS);
    end

    drain_results();
    if (due_outputs.size() != 0) begin
      $error("%0d results never arrived", due_outputs.size());
      err_cnt++;
    end

    $display("Ran %0d live requests: %0d pulse toggles, %0d limit stops, %0d homing stops.",
             live_cnt, toggle_cnt, limit_cnt, zero_cnt);
    $display("Directed table plus %0d random register settings, idling on both channels.",
             setting_cnt);
    if (err_cnt == 0) begin
      $display("stepper_pulse_generator_with_homing test passed");
    end else begin
      $display("stepper_pulse_generator_with_homing test failed");
    end
    $finish;
  end

endmodule
